>>> rtl/core/fmv_pkg.sv
// Shared types, constants and the quarter-wave sine table for the FM voice.
// No dependencies.
package fmv_pkg;

    localparam int PhaseW    = 32;
    localparam int LenW      = 20;
    localparam int TimerW    = 22;
    localparam int LevelW    = 24;
    localparam int DepthW    = 16;
    localparam int SampleW   = 16;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 32;
    localparam int TableIdxW = 10;
    localparam int QuotW     = 24;
    localparam int MulAW     = 26;
    localparam int MulBW     = 32;
    localparam int ProdW     = MulAW + MulBW;

    localparam logic [LevelW-1:0] LevelOne = 24'd8388608;
    localparam logic [TimerW-1:0] TimerMax = 22'd4194303;
    localparam logic [MulBW-1:0]  InvTwoPi = 32'd683565276;

    localparam logic [CfgIdxW-1:0] CfgCarStep = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgModAtt  = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgModHold = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgModRel  = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgAmpAtt  = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgAmpHold = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgAmpRel  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_MOD, S_WAIT_MOD, S_DIV_AMP, S_WAIT_AMP,
        S_LOOK_MOD, S_MUL_Q, S_MUL_M, S_MUL_OFF, S_LOOK_CAR, S_MUL_Y, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_Q, MUL_M, MUL_OFF, MUL_Y
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    env_upd;
        logic    env_sel;
        logic    look_mod;
        logic    look_car;
        logic    mul_en;
        mul_op_t mul_op;
        logic    finish;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;

    typedef logic [14:0] quarter_t [256];

    function automatic logic [14:0] sine_mag(input logic [63:0] r);
        logic [63:0] x, x2, t, s, v;
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 64'd110;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

    function automatic quarter_t build_quarter();
        quarter_t q;
        for (int i = 0; i < 256; i++)
        begin
            q[i] = sine_mag(64'(i) << 22);
        end
        return q;
    endfunction

    localparam quarter_t Quarter = build_quarter();
    localparam logic [14:0] Peak = sine_mag(64'd1 << 30);

    function automatic logic signed [SampleW-1:0] sine_lookup(
        input logic [TableIdxW-1:0] idx);
        logic [7:0]  j;
        logic [14:0] mag;
        j = idx[7:0];
        if (idx[8])
        begin
            mag = (j == 8'd0) ? Peak : Quarter[8'(~j + 8'd1)];
        end
        else
        begin
            mag = Quarter[j];
        end
        return idx[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

>>> rtl/core/fmv_in_if.sv
// Input channel of the FM voice: valid/ready with trigger and depth.
// Depends on fmv_pkg.
interface fmv_in_if;
    import fmv_pkg::*;
    logic              valid;
    logic              ready;
    logic              trigger;
    logic [DepthW-1:0] random_depth;
    modport source (output valid, output trigger, output random_depth, input ready);
    modport sink (input valid, input trigger, input random_depth, output ready);
endinterface

>>> rtl/core/fmv_out_if.sv
// Output channel of the FM voice: valid/ready with one audio sample.
// Depends on fmv_pkg.
interface fmv_out_if;
    import fmv_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] audio_sample;
    modport source (output valid, output audio_sample, input ready);
    modport sink (input valid, input audio_sample, output ready);
endinterface

>>> rtl/core/fmv_div.sv
// Iterative restoring divider, one quotient bit per cycle, for envelope steps.
// Depends on fmv_pkg.
module fmv_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fmv_pkg::QuotW-1:0] dividend,
    input  logic [fmv_pkg::LenW-1:0]  divisor,
    output logic [fmv_pkg::QuotW-1:0] quotient,
    output logic                      done
);
    import fmv_pkg::*;

    logic [QuotW-1:0] acc_reg, acc_next;
    logic [LenW-1:0]  rem_reg, rem_next;
    logic [LenW-1:0]  dvs_reg;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [LenW:0]    trial;

    always_comb
    begin
        trial     = {rem_reg, acc_reg[QuotW-1]};
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = dividend;
            rem_next  = '0;
            cnt_next  = 5'(QuotW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = LenW'(trial - {1'b0, dvs_reg});
                acc_next = {acc_reg[QuotW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[LenW-1:0];
                acc_next = {acc_reg[QuotW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = acc_reg;
    assign done     = done_reg;
endmodule

>>> rtl/core/fmv_datapath.sv
// Datapath: configuration, phase counter, envelopes, shared multiplier, sine lookup.
// Depends on fmv_pkg and fmv_div.
module fmv_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fmv_pkg::dp_cmd_t                   cmd,
    output fmv_pkg::dp_stat_t                  stat,
    input  logic                               trigger,
    input  logic [fmv_pkg::DepthW-1:0]         random_depth,
    input  logic                               cfg_we,
    input  logic [fmv_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [fmv_pkg::CfgDataW-1:0]       cfg_data,
    output logic signed [fmv_pkg::SampleW-1:0] audio_sample
);
    import fmv_pkg::*;

    logic [PhaseW-1:0] step_reg;
    logic [LenW-1:0]   matt_reg, mhold_reg, mrel_reg, aatt_reg, ahold_reg, arel_reg;
    logic [PhaseW:0]   phase_reg;
    logic [TimerW-1:0] mtim_reg, atim_reg;
    logic [LevelW-1:0] mlev_reg, alev_reg;
    logic [DepthW-1:0] depth_reg;

    logic signed [SampleW-1:0] sine_reg;
    logic signed [ProdW-1:0]   prod_reg;
    logic signed [SampleW-1:0] sample_reg;

    logic [TimerW-1:0] tim, t1, t2, t3, tim_new;
    logic [LevelW-1:0] lev, lev_new;
    logic [LenW-1:0]   att, hold, rel, dlen;
    logic [LevelW:0]   lsum;
    logic [QuotW-1:0]  quot;
    logic              in_att, in_hold, in_rel;

    logic signed [ProdW-1:0]  r15, r16, r20, r24;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic [TableIdxW-1:0]     tidx;
    logic [PhaseW-1:0]        car_addr;

    fmv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (LevelOne + QuotW'(dlen[LenW-1:1])),
        .divisor  (dlen),
        .quotient (quot),
        .done     (stat.div_done)
    );

    always_comb
    begin
        tim  = cmd.env_sel ? atim_reg : mtim_reg;
        lev  = cmd.env_sel ? alev_reg : mlev_reg;
        att  = cmd.env_sel ? aatt_reg : matt_reg;
        hold = cmd.env_sel ? ahold_reg : mhold_reg;
        rel  = cmd.env_sel ? arel_reg : mrel_reg;
        t1   = TimerW'(att);
        t2   = t1 + TimerW'(hold);
        t3   = t2 + TimerW'(rel);
        in_att  = tim < t1;
        in_hold = tim < t2;
        in_rel  = tim < t3;
        dlen = in_att ? att : rel;
        lsum = {1'b0, lev} + {1'b0, quot};
        if (in_att)
        begin
            lev_new = (lsum > {1'b0, LevelOne}) ? LevelOne : lsum[LevelW-1:0];
        end
        else if (in_hold)
        begin
            lev_new = LevelOne;
        end
        else if (in_rel)
        begin
            lev_new = (lev > quot) ? lev - quot : '0;
        end
        else
        begin
            lev_new = '0;
        end
        tim_new = (tim < TimerMax) ? tim + 22'd1 : tim;
    end

    always_comb
    begin
        r15 = (prod_reg + (ProdW'(1) <<< 14)) >>> 15;
        r16 = (prod_reg + (ProdW'(1) <<< 15)) >>> 16;
        r20 = (prod_reg + (ProdW'(1) <<< 19)) >>> 20;
        r24 = (prod_reg + (ProdW'(1) <<< 23)) >>> 24;
        case (cmd.mul_op)
            MUL_Q:
            begin
                mul_a = MulAW'(sine_reg);
                mul_b = $signed(MulBW'(mlev_reg));
            end
            MUL_M:
            begin
                mul_a = r15[MulAW-1:0];
                mul_b = $signed(MulBW'(depth_reg));
            end
            MUL_OFF:
            begin
                mul_a = r16[MulAW-1:0];
                mul_b = $signed(InvTwoPi);
            end
            MUL_Y:
            begin
                mul_a = MulAW'(sine_reg);
                mul_b = $signed(MulBW'(alev_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        car_addr = phase_reg[PhaseW-1:0] + r20[PhaseW-1:0];
        tidx = cmd.look_car ? car_addr[PhaseW-1 -: TableIdxW]
                            : phase_reg[PhaseW -: TableIdxW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 32'd10737418;
            matt_reg  <= 20'd48;
            mhold_reg <= 20'd2400;
            mrel_reg  <= 20'd9600;
            aatt_reg  <= 20'd48;
            ahold_reg <= 20'd9600;
            arel_reg  <= 20'd24000;
            phase_reg <= '0;
            mtim_reg  <= TimerMax;
            atim_reg  <= TimerMax;
            mlev_reg  <= '0;
            alev_reg  <= '0;
            depth_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CfgCarStep: step_reg  <= cfg_data;
                    CfgModAtt:  matt_reg  <= cfg_data[LenW-1:0];
                    CfgModHold: mhold_reg <= cfg_data[LenW-1:0];
                    CfgModRel:  mrel_reg  <= cfg_data[LenW-1:0];
                    CfgAmpAtt:  aatt_reg  <= cfg_data[LenW-1:0];
                    CfgAmpHold: ahold_reg <= cfg_data[LenW-1:0];
                    CfgAmpRel:  arel_reg  <= cfg_data[LenW-1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                if (trigger)
                begin
                    depth_reg <= random_depth;
                    mtim_reg  <= '0;
                    atim_reg  <= '0;
                    mlev_reg  <= '0;
                    alev_reg  <= '0;
                end
            end
            if (cmd.env_upd)
            begin
                if (cmd.env_sel)
                begin
                    atim_reg <= tim_new;
                    alev_reg <= lev_new;
                end
                else
                begin
                    mtim_reg <= tim_new;
                    mlev_reg <= lev_new;
                end
            end
            if (cmd.finish)
            begin
                phase_reg <= phase_reg + {1'b0, step_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.look_mod || cmd.look_car)
        begin
            sine_reg <= sine_lookup(tidx);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.finish)
        begin
            sample_reg <= r24[SampleW-1:0];
        end
    end

    assign audio_sample = sample_reg;
endmodule

>>> rtl/core/fmv_ctrl.sv
// Controller: sequences one sample through the datapath and owns the handshakes.
// Depends on fmv_pkg.
module fmv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output fmv_pkg::dp_cmd_t  cmd,
    input  fmv_pkg::dp_stat_t stat
);
    import fmv_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        cmd.mul_op = MUL_Q;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV_MOD;
                end
            end
            S_DIV_MOD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_MOD;
            end
            S_WAIT_MOD:
            begin
                if (stat.div_done)
                begin
                    cmd.env_upd = 1'b1;
                    state_next  = S_DIV_AMP;
                end
            end
            S_DIV_AMP:
            begin
                cmd.env_sel   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_AMP;
            end
            S_WAIT_AMP:
            begin
                cmd.env_sel = 1'b1;
                if (stat.div_done)
                begin
                    cmd.env_upd = 1'b1;
                    state_next  = S_LOOK_MOD;
                end
            end
            S_LOOK_MOD:
            begin
                cmd.look_mod = 1'b1;
                state_next   = S_MUL_Q;
            end
            S_MUL_Q:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_Q;
                state_next = S_MUL_M;
            end
            S_MUL_M:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_M;
                state_next = S_MUL_OFF;
            end
            S_MUL_OFF:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_OFF;
                state_next = S_LOOK_CAR;
            end
            S_LOOK_CAR:
            begin
                cmd.look_car = 1'b1;
                state_next   = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_Y;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;
endmodule

>>> rtl/core/fm_voice_with_ahr_envelopes.sv
// Two-operator FM voice with attack-hold-release envelopes, top level.
// Depends on fmv_pkg, fmv_in_if, fmv_out_if, fmv_ctrl and fmv_datapath.
//
// Usage: one input transfer per audio sample carries trigger and random_depth;
// each one yields exactly one audio_sample transfer on the output channel.
// Registers are written through cfg_we/cfg_index/cfg_data; write them only
// while idle, which the block itself does not enforce. Between input transfer
// and output valid, two runs of the shared iterative divider (start, 24
// quotient bits, done) form the envelope steps; a new input is taken only
// once the previous sample has been moved into the output register.
// The result sits in an output register, so the next input is taken while
// it waits; a stalled receiver holds the next item in its last state
// until the register frees up. Reset loads the default register values,
// clears phase, levels and depth, and leaves both envelopes ended.
module fm_voice_with_ahr_envelopes (
    input  logic                         clk,
    input  logic                         rst_n,
    fmv_in_if.sink                       in_ch,
    fmv_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [fmv_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [fmv_pkg::CfgDataW-1:0] cfg_data
);
    import fmv_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    fmv_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .trigger      (in_ch.trigger),
        .random_depth (in_ch.random_depth),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .audio_sample (out_ch.audio_sample)
    );
endmodule
